### design/dlmis_pkg.sv
// Shared types, constants and helpers for the desire-level MIS node.
package dlmis_pkg;

    localparam int MAX_NODES      = 64;
    localparam int ROUND_BITS_DEF = 16;
    localparam int ID_W           = 6;
    localparam int EXP_W          = 5;
    localparam int MROUND_W       = 16;
    localparam int FRAC_W         = 32;
    localparam int SUM_W          = 39;
    localparam int MASK_W         = 64;
    localparam int FIFO_DEPTH     = 4;
    localparam int PTR_W          = $clog2(FIFO_DEPTH);
    localparam int CNT_W          = $clog2(FIFO_DEPTH + 1);

    localparam logic [EXP_W-1:0]  MAX_EXP   = EXP_W'(30);
    localparam logic [MASK_W-1:0] NODE_MASK = (MAX_NODES >= MASK_W) ? {MASK_W{1'b1}} :
                                              ((MASK_W'(1) << MAX_NODES) - MASK_W'(1));

    localparam int OUT_INSET_BIT = 28;
    localparam int OUT_DONE_BIT  = 29;

    typedef enum logic [2:0] {
        ACT_ROUND     = 3'd0,
        ACT_DESIRE    = 3'd1,
        ACT_MARK      = 3'd2,
        ACT_RX_DESIRE = 3'd3,
        ACT_RX_MARK   = 3'd4,
        ACT_RX_JOIN   = 3'd5,
        ACT_RX_TERM   = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        KIND_DESIRE = 2'd0,
        KIND_MARK   = 2'd1,
        KIND_JOIN   = 2'd2,
        KIND_TERM   = 2'd3
    } msg_kind_t;

    typedef enum logic {
        CFG_OWN_ID   = 1'b0,
        CFG_NBR_MASK = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic                last;
        logic                done_res;
        logic                in_set;
        logic                out_marked;
        logic [EXP_W-1:0]    out_desire_exp;
        logic [MROUND_W-1:0] out_round;
        logic [ID_W-1:0]     from_id;
        msg_kind_t           msg_kind;
    } res_t;

    function automatic logic [FRAC_W-1:0] level_of(input logic [EXP_W-1:0] k);
        return {1'b1, {(FRAC_W-1){1'b0}}} >> k;
    endfunction

endpackage

### design/desire_level_mis_node_core.sv
// Desire-level MIS node: one protocol node with its neighbor level memory.
//
// Usage: actions (timer events and received neighbor messages) enter on the
// s_ stream; s_tuser carries the action code, s_tdata the message fields.
// Broadcasts leave on the m_ stream; m_tuser carries the message kind and
// m_tlast marks the final broadcast caused by one action. Node id and the
// initial neighbor mask are to be written on the cfg_ channel only while
// the node idles, which the node itself does not enforce. Each action has
// a read step, which fetches the neighbor's stored level from the level
// memory as the beat is taken, and an update step (ST_EXEC) that updates
// state, writes the memory back and queues the broadcasts. No new action
// is taken until the update step is done.
// Broadcasts wait in a 4-entry queue; an action beat is taken only while two
// queue slots are free, so a stalled receiver holds off input once the queue
// fills. Actions keep flowing while earlier broadcasts wait.
// Reset clears all node state, the neighbor valid and removed bits and the
// queue; the level memory is not cleared since valid bits guard every read.
module desire_level_mis_node_core #(
    parameter int ROUND_BITS = dlmis_pkg::ROUND_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sender_id[5:0], msg_round[21:6], desire_exp[26:22], sender_marked[27],
    // rand_fraction[59:28], zero pad[63:60]
    input  logic [63:0] s_tdata,
    // action[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // from_id[5:0], out_round[21:6], out_desire_exp[26:22], out_marked[27],
    // in_set[28], done_res[29], zero pad[31:30]
    output logic [31:0] m_tdata,
    // msg_kind[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int ID_W   = dlmis_pkg::ID_W;
    localparam int EXP_W  = dlmis_pkg::EXP_W;
    localparam int MR_W   = dlmis_pkg::MROUND_W;
    localparam int FRAC_W = dlmis_pkg::FRAC_W;
    localparam int SUM_W  = dlmis_pkg::SUM_W;
    localparam int MASK_W = dlmis_pkg::MASK_W;
    localparam int PTR_W  = dlmis_pkg::PTR_W;
    localparam int CNT_W  = dlmis_pkg::CNT_W;

    dlmis_pkg::state_t    state_reg, state_next;
    dlmis_pkg::action_t   act_reg;
    logic [ID_W-1:0]      sender_reg;
    logic [MR_W-1:0]      mround_reg;
    logic [EXP_W-1:0]     dexp_reg;
    logic                 smarked_reg;
    logic [FRAC_W-1:0]    rand_reg;
    logic [EXP_W-1:0]     lvl_rd_reg;

    logic [ID_W-1:0]      own_id_reg;
    logic [MASK_W-1:0]    nbr_mask_reg;

    logic [ROUND_BITS-1:0] round_reg, round_next;
    logic [EXP_W-1:0]     exp_reg, exp_next;
    logic                 smark_reg, smark_next;
    logic                 nmark_reg, nmark_next;
    logic                 joined_reg, joined_next;
    logic                 fin_reg, fin_next;
    logic [MASK_W-1:0]    removed_reg, removed_next;
    logic [MASK_W-1:0]    valid_reg, valid_next;
    logic [SUM_W-1:0]     dsum_reg, dsum_next;

    logic [EXP_W-1:0]     level_mem [MASK_W];
    logic                 mem_we;

    dlmis_pkg::res_t      fifo_reg [dlmis_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    logic                 s_accept;
    logic                 m_pop;
    logic                 exec;
    logic [MASK_W-1:0]    active;
    logic                 sender_act;
    logic                 round_ok;
    logic [31:0]          round_ext;
    logic [SUM_W-1:0]     old_lvl;
    logic [SUM_W-1:0]     new_lvl;
    logic                 nm;
    logic [1:0]           n_res;
    dlmis_pkg::msg_kind_t kind0, kind1;
    dlmis_pkg::res_t      res0, res1;
    dlmis_pkg::res_t      head;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == dlmis_pkg::ST_IDLE) && (cnt_reg <= CNT_W'(2));
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = (cnt_reg != '0);
    assign m_pop     = m_tvalid && m_tready;
    assign exec      = (state_reg == dlmis_pkg::ST_EXEC);

    assign head    = fifo_reg[rd_ptr_reg];
    assign m_tdata = {2'b00, head.done_res, head.in_set, head.out_marked,
                      head.out_desire_exp, head.out_round, head.from_id};
    assign m_tuser = head.msg_kind;
    assign m_tlast = head.last;

    assign active     = nbr_mask_reg & ~removed_reg & dlmis_pkg::NODE_MASK;
    assign sender_act = active[sender_reg];
    assign round_ext  = 32'(round_reg);
    assign round_ok   = (mround_reg == round_ext[MR_W-1:0]);
    assign old_lvl    = valid_reg[sender_reg] ?
                        SUM_W'(dlmis_pkg::level_of(lvl_rd_reg)) : '0;
    assign new_lvl    = SUM_W'(dlmis_pkg::level_of(dexp_reg));

    always_comb begin
        state_next   = state_reg;
        round_next   = round_reg;
        exp_next     = exp_reg;
        smark_next   = smark_reg;
        nmark_next   = nmark_reg;
        joined_next  = joined_reg;
        fin_next     = fin_reg;
        removed_next = removed_reg;
        valid_next   = valid_reg;
        dsum_next    = dsum_reg;
        mem_we       = 1'b0;
        n_res        = 2'd0;
        kind0        = dlmis_pkg::KIND_DESIRE;
        kind1        = dlmis_pkg::KIND_TERM;
        nm           = nmark_reg | smarked_reg;

        unique case (state_reg)
            dlmis_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = dlmis_pkg::ST_EXEC;
                end
            end
            dlmis_pkg::ST_EXEC: begin
                state_next = dlmis_pkg::ST_IDLE;
            end
            default: begin
                state_next = dlmis_pkg::ST_IDLE;
            end
        endcase

        if (exec && !fin_reg) begin
            unique case (act_reg)
                dlmis_pkg::ACT_ROUND: begin
                    round_next = round_reg + ROUND_BITS'(1);
                    smark_next = 1'b0;
                    nmark_next = 1'b0;
                    if (dsum_reg[SUM_W-1:FRAC_W+1] != '0) begin
                        exp_next = (exp_reg < dlmis_pkg::MAX_EXP) ?
                                   exp_reg + EXP_W'(1) : dlmis_pkg::MAX_EXP;
                    end else if (exp_reg != '0) begin
                        exp_next = exp_reg - EXP_W'(1);
                    end
                    if (active == '0) begin
                        joined_next = 1'b1;
                        fin_next    = 1'b1;
                        n_res       = 2'd2;
                        kind0       = dlmis_pkg::KIND_JOIN;
                    end
                end
                dlmis_pkg::ACT_DESIRE: begin
                    n_res = 2'd1;
                    kind0 = dlmis_pkg::KIND_DESIRE;
                end
                dlmis_pkg::ACT_MARK: begin
                    smark_next = rand_reg < dlmis_pkg::level_of(exp_reg);
                    n_res      = 2'd1;
                    kind0      = dlmis_pkg::KIND_MARK;
                end
                dlmis_pkg::ACT_RX_DESIRE: begin
                    if (round_ok && sender_act) begin
                        mem_we                 = 1'b1;
                        valid_next[sender_reg] = 1'b1;
                        dsum_next              = dsum_reg - old_lvl + new_lvl;
                    end
                end
                dlmis_pkg::ACT_RX_MARK: begin
                    if (round_ok && sender_act) begin
                        nmark_next = nm;
                        if (smark_reg && !nm) begin
                            joined_next = 1'b1;
                            fin_next    = 1'b1;
                            n_res       = 2'd2;
                            kind0       = dlmis_pkg::KIND_JOIN;
                        end
                    end
                end
                dlmis_pkg::ACT_RX_JOIN: begin
                    if (sender_act) begin
                        removed_next[sender_reg] = 1'b1;
                        valid_next[sender_reg]   = 1'b0;
                        dsum_next                = dsum_reg - old_lvl;
                        fin_next                 = 1'b1;
                        n_res                    = 2'd1;
                        kind0                    = dlmis_pkg::KIND_TERM;
                    end
                end
                dlmis_pkg::ACT_RX_TERM: begin
                    if (sender_act) begin
                        removed_next[sender_reg] = 1'b1;
                        valid_next[sender_reg]   = 1'b0;
                        dsum_next                = dsum_reg - old_lvl;
                    end
                end
                default: begin
                end
            endcase
        end

        res0.msg_kind       = kind0;
        res0.from_id        = own_id_reg;
        res0.out_round      = MR_W'(32'(round_next));
        res0.out_desire_exp = exp_next;
        res0.out_marked     = smark_next;
        res0.in_set         = joined_next;
        res0.done_res       = (kind0 == dlmis_pkg::KIND_TERM);
        res0.last           = (n_res == 2'd1);
        res1                = res0;
        res1.msg_kind       = kind1;
        res1.done_res       = 1'b1;
        res1.last           = 1'b1;

        wr_ptr_next = wr_ptr_reg + PTR_W'(n_res);
        rd_ptr_next = rd_ptr_reg + PTR_W'(m_pop);
        cnt_next    = cnt_reg + CNT_W'(n_res) - CNT_W'(m_pop);
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            lvl_rd_reg <= level_mem[s_tdata[5:0]];
        end
        if (mem_we) begin
            level_mem[sender_reg] <= dexp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            act_reg     <= dlmis_pkg::action_t'(s_tuser);
            sender_reg  <= s_tdata[5:0];
            mround_reg  <= s_tdata[21:6];
            dexp_reg    <= s_tdata[26:22];
            smarked_reg <= s_tdata[27];
            rand_reg    <= s_tdata[59:28];
        end
        if (n_res != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res0;
        end
        if (n_res == 2'd2) begin
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= dlmis_pkg::ST_IDLE;
            own_id_reg   <= '0;
            nbr_mask_reg <= '0;
            round_reg    <= '0;
            exp_reg      <= '0;
            smark_reg    <= 1'b0;
            nmark_reg    <= 1'b0;
            joined_reg   <= 1'b0;
            fin_reg      <= 1'b0;
            removed_reg  <= '0;
            valid_reg    <= '0;
            dsum_reg     <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            exp_reg     <= exp_next;
            smark_reg   <= smark_next;
            nmark_reg   <= nmark_next;
            joined_reg  <= joined_next;
            fin_reg     <= fin_next;
            removed_reg <= removed_next;
            valid_reg   <= valid_next;
            dsum_reg    <= dsum_next;
            wr_ptr_reg  <= wr_ptr_next;
            rd_ptr_reg  <= rd_ptr_next;
            cnt_reg     <= cnt_next;
            if (cfg_valid && cfg_ready) begin
                unique case (dlmis_pkg::cfg_index_t'(cfg_index))
                    dlmis_pkg::CFG_OWN_ID:   own_id_reg   <= cfg_data[ID_W-1:0];
                    dlmis_pkg::CFG_NBR_MASK: nbr_mask_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

### design/dlmis_checker.sv
// Port-level checker for the desire-level MIS node, bound to the top level.
module dlmis_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    a_out_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result beat changed");

    a_join_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == dlmis_pkg::KIND_JOIN) |->
            !m_tlast && m_tdata[dlmis_pkg::OUT_INSET_BIT]
            && !m_tdata[dlmis_pkg::OUT_DONE_BIT])
        else $error("join beat has wrong flags");

    a_join_then_term: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && (m_tuser == dlmis_pkg::KIND_JOIN) |=>
            m_tvalid && (m_tuser == dlmis_pkg::KIND_TERM) && m_tlast
            && m_tdata[dlmis_pkg::OUT_INSET_BIT])
        else $error("join beat not followed by terminate beat");

    a_term_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == dlmis_pkg::KIND_TERM) |->
            m_tlast && m_tdata[dlmis_pkg::OUT_DONE_BIT])
        else $error("terminate beat without done flag");

endmodule

bind desire_level_mis_node_core dlmis_checker u_dlmis_checker (.*);
